### sv/lpaxd_pkg.sv
// Shared types and constants of the length-prefixed autokey XOR deframer.
package lpaxd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SEED_W    = 8;
	localparam int unsigned MAXLEN_W  = 24;
	localparam int unsigned LEFT_W    = 24;
	localparam int unsigned CMP_W     = 32;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 24;

	localparam logic [SEED_W-1:0]   SEED_RESET   = 8'd171;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 24'd4096;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 1'd1;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} stage_t;

	typedef struct packed {
		logic [BYTE_W-1:0] plain_byte;
		logic              frame_end;
		logic              empty_frame;
		logic              length_error;
	} res_t;

endpackage

### sv/lpaxd_ifs.sv
// Stream interfaces for received bytes and for deframed result beats.
interface lpaxd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface lpaxd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_byte;
	logic       frame_end;
	logic       empty_frame;
	logic       length_error;

	modport source (output valid, output plain_byte, output frame_end,
		output empty_frame, output length_error, input ready);
	modport sink (input valid, input plain_byte, input frame_end,
		input empty_frame, input length_error, output ready);
endinterface

### sv/lpaxd_in_stage.sv
// Input register that holds one received byte until the deframer core takes it.
module lpaxd_in_stage
	import lpaxd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	lpaxd_byte_if.sink rx,
	input  logic  take,
	output stage_t stage
);

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;

	assign rx.ready = !valid_s1 || take;
	assign stage.valid = valid_s1;
	assign stage.data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			data_s1 <= rx.in_byte;
		end
	end

endmodule

### sv/lpaxd_core.sv
// Header parser, autokey XOR decipher, configuration registers and result register.
module lpaxd_core
	import lpaxd_pkg::*;
#(
	parameter int unsigned HEADER_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	input  stage_t               stage,
	output logic                 take,
	lpaxd_res_if.source          res
);

	localparam int unsigned LEN_W  = 8 * HEADER_BYTES;
	localparam int unsigned HIDX_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
	localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HEADER_BYTES - 1);

	logic [SEED_W-1:0]   seed_q;
	logic [MAXLEN_W-1:0] maxlen_q;
	logic                in_payload_q;
	logic [HIDX_W-1:0]   hidx_q;
	logic [LEN_W-1:0]    accum_q;
	logic [LEFT_W-1:0]   left_q;
	logic [BYTE_W-1:0]   key_q;
	logic                res_valid_q;
	res_t                res_q;

	logic [LEN_W-1:0] accum_nx;
	logic [CMP_W-1:0] len_full;
	logic             hdr_last;
	logic             len_zero;
	logic             len_over;
	logic             gen;
	res_t             res_nx;

	assign take = stage.valid && (!res_valid_q || res.ready);

	assign accum_nx = (accum_q << 8) | LEN_W'(stage.data);
	assign len_full = CMP_W'(accum_nx);
	assign hdr_last = (hidx_q == HIDX_LAST);
	assign len_zero = (accum_nx == '0);
	assign len_over = (len_full > CMP_W'(maxlen_q));

	always_comb begin
		gen = 1'b0;
		res_nx = '0;
		if (in_payload_q) begin
			gen = 1'b1;
			res_nx.plain_byte = stage.data ^ key_q;
			res_nx.frame_end = (left_q == LEFT_W'(1));
		end else if (hdr_last) begin
			if (len_zero) begin
				gen = 1'b1;
				res_nx.frame_end = 1'b1;
				res_nx.empty_frame = 1'b1;
			end else if (len_over) begin
				gen = 1'b1;
				res_nx.frame_end = 1'b1;
				res_nx.length_error = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			maxlen_q <= MAXLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_SEED: seed_q <= cfg_wdata[SEED_W-1:0];
				REG_MAX_LEN:  maxlen_q <= cfg_wdata[MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hidx_q <= '0;
			accum_q <= '0;
			left_q <= '0;
			key_q <= SEED_RESET;
		end else if (take) begin
			if (in_payload_q) begin
				key_q <= stage.data;
				left_q <= left_q - LEFT_W'(1);
				if (left_q == LEFT_W'(1)) begin
					in_payload_q <= 1'b0;
					hidx_q <= '0;
					accum_q <= '0;
				end
			end else if (!hdr_last) begin
				accum_q <= accum_nx;
				hidx_q <= hidx_q + HIDX_W'(1);
			end else begin
				hidx_q <= '0;
				accum_q <= '0;
				if (!len_zero && !len_over) begin
					left_q <= len_full[LEFT_W-1:0];
					key_q <= seed_q;
					in_payload_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && gen) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && gen) begin
			res_q <= res_nx;
		end
	end

	assign res.valid = res_valid_q;
	assign res.plain_byte = res_q.plain_byte;
	assign res.frame_end = res_q.frame_end;
	assign res.empty_frame = res_q.empty_frame;
	assign res.length_error = res_q.length_error;

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.empty_frame && res_q.length_error))
		else $error("empty and error flags both set");

	a_flag_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.empty_frame || res_q.length_error)) |->
		(res_q.frame_end && res_q.plain_byte == '0))
		else $error("flagged result does not close frame with zero byte");

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (left_q != '0))
		else $error("payload active with no bytes left");

	a_hdr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (hidx_q == '0 && accum_q == '0))
		else $error("header state not cleared during payload");

	a_take_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(take && gen) |=> res_valid_q)
		else $error("result lost on take");

endmodule

### sv/length_prefixed_autokey_xor_deframer.sv
// Top level of the length-prefixed autokey XOR deframer.
// The block takes one received byte per cycle while the result register is free or being
// taken; a byte is registered at the input and held until the core takes it, and any
// result beat it yields is registered in the result register. Header, counter and XOR
// logic lie in a single pass between the input register and the result register. Input
// ready drops only while a byte is held and the result register is full and not being taken.
module length_prefixed_autokey_xor_deframer
	import lpaxd_pkg::*;
#(
	parameter int unsigned HEADER_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	lpaxd_byte_if.sink           rx,
	lpaxd_res_if.source          res
);

	stage_t stage;
	logic   take;

	lpaxd_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.stage  (stage)
	);

	lpaxd_core #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.stage     (stage),
		.take      (take),
		.res       (res)
	);

endmodule

### verif/lpaxd_deframe_checker.sv
`timescale 1ns / 1ps
// Checker that rebuilds the expected deframed result beats from accepted bytes and compares them.
module lpaxd_deframe_checker
	import lpaxd_pkg::*;
#(
	parameter int unsigned HDR_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	lpaxd_byte_if                rx,
	lpaxd_res_if                 res,
	output int                   mismatches,
	output int                   outstanding
);

	logic [SEED_W-1:0]   seed;
	logic [MAXLEN_W-1:0] max_len;
	logic                in_payload;
	int unsigned         hdr_count;
	logic [CMP_W-1:0]    len_acc;
	logic [LEFT_W-1:0]   remaining;
	logic [BYTE_W-1:0]   key;
	res_t                deframed_q[$];
	res_t                got;
	res_t                want;
	int                  bad;

	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		res_t             r;
		logic [CMP_W-1:0] max_wide;
		r = '0;
		max_wide = '0;
		max_wide[MAXLEN_W-1:0] = max_len;
		if (in_payload) begin
			r.plain_byte = b ^ key;
			key = b;
			remaining = remaining - LEFT_W'(1);
			if (remaining == '0) begin
				r.frame_end = 1'b1;
				in_payload = 1'b0;
				hdr_count = 0;
				len_acc = '0;
			end
			deframed_q.push_back(r);
		end else begin
			len_acc = {len_acc[CMP_W-BYTE_W-1:0], b};
			if (hdr_count + 1 < HDR_BYTES) begin
				hdr_count++;
			end else begin
				hdr_count = 0;
				if (len_acc == '0) begin
					r.frame_end = 1'b1;
					r.empty_frame = 1'b1;
					deframed_q.push_back(r);
				end else if (len_acc > max_wide) begin
					r.frame_end = 1'b1;
					r.length_error = 1'b1;
					deframed_q.push_back(r);
				end else begin
					remaining = len_acc[LEFT_W-1:0];
					key = seed;
					in_payload = 1'b1;
				end
				len_acc = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed = SEED_RESET;
			max_len = MAXLEN_RESET;
			in_payload = 1'b0;
			hdr_count = 0;
			len_acc = '0;
			remaining = '0;
			key = SEED_RESET;
			deframed_q.delete();
			bad = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_KEY_SEED) begin
					seed = cfg_wdata[SEED_W-1:0];
				end else if (cfg_index == REG_MAX_LEN) begin
					max_len = cfg_wdata[MAXLEN_W-1:0];
				end
			end
			if (rx.valid && rx.ready) begin
				deframe_byte(rx.in_byte);
			end
			if (res.valid && res.ready) begin
				got = {res.plain_byte, res.frame_end, res.empty_frame, res.length_error};
				if (deframed_q.size() == 0) begin
					bad++;
					if (bad <= 10) begin
						$display("%0t: result beat with nothing pending: plain=%02h end=%0b empty=%0b err=%0b",
							$realtime, got.plain_byte, got.frame_end, got.empty_frame,
							got.length_error);
					end
				end else begin
					want = deframed_q.pop_front();
					if (got.plain_byte !== want.plain_byte || got.frame_end !== want.frame_end ||
						got.empty_frame !== want.empty_frame ||
						got.length_error !== want.length_error) begin
						bad++;
						if (bad <= 10) begin
							$display("%0t: mismatch: expected plain=%02h end=%0b empty=%0b err=%0b",
								$realtime, want.plain_byte, want.frame_end, want.empty_frame,
								want.length_error);
							$display("%0t:           actual   plain=%02h end=%0b empty=%0b err=%0b",
								$realtime, got.plain_byte, got.frame_end, got.empty_frame,
								got.length_error);
						end
					end
				end
			end
			mismatches <= bad;
			outstanding <= deframed_q.size();
		end
	end

endmodule

### verif/tb_length_prefixed_autokey_xor_deframer.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, framed byte stimulus, result back-pressure and the verdict.
module tb_length_prefixed_autokey_xor_deframer;
	import lpaxd_pkg::*;

	localparam int unsigned HDR_BYTES    = 4;
	localparam int unsigned IDLE_PCT     = 30;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int          PHASE_BYTES  = 250;

	typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;
	int                   mismatches;
	int                   outstanding;

	logic [MAXLEN_W-1:0]  cur_max;
	bit                   steady;
	int                   hold_reqs;
	int                   holds_done;
	int unsigned          hold_left;
	int                   bytes_sent;

	lpaxd_byte_if rx_if();
	lpaxd_res_if  res_if();

	length_prefixed_autokey_xor_deframer #(
		.HEADER_BYTES(HDR_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rx(rx_if),
		.res(res_if)
	);

	lpaxd_deframe_checker #(
		.HDR_BYTES(HDR_BYTES)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rx(rx_if),
		.res(res_if),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		res_if.ready = 1'b0;
		holds_done = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_reqs != holds_done) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				res_if.ready <= 1'b0;
			end else if (steady) begin
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				rx_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		rx_if.valid <= 1'b1;
		rx_if.in_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic quiesce();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input logic [31:0] len, input fill_t fill);
		logic [BYTE_W-1:0] b;
		for (int i = HDR_BYTES - 1; i >= 0; i--) begin
			send_byte(len[i*8 +: 8]);
		end
		if (len != 0 && len <= {8'h00, cur_max}) begin
			for (int unsigned n = 0; n < len; n++) begin
				case (fill)
					FILL_ZERO: b = 8'h00;
					FILL_ONES: b = 8'hFF;
					default: b = BYTE_W'($urandom_range(255));
				endcase
				send_byte(b);
			end
		end
	endtask

	task automatic send_random_frame();
		int unsigned pick;
		int unsigned cap;
		logic [31:0] len;
		pick = $urandom_range(99);
		cap = (cur_max < 24) ? cur_max : 24;
		if (pick < 60) begin
			len = (cap == 0) ? 32'd0 : $urandom_range(cap, 1);
		end else if (pick < 70) begin
			len = 32'd0;
		end else if (pick < 80) begin
			len = {8'h00, cur_max} + 32'd1;
		end else if (pick < 85) begin
			len = (cur_max <= 64) ? {8'h00, cur_max} : $urandom_range(cap, 1);
		end else begin
			len = $urandom();
			if (len <= {8'h00, cur_max} && len > 64) begin
				len[31] = 1'b1;
			end
		end
		send_frame(len, FILL_RANDOM);
	endtask

	initial begin
		logic [SEED_W-1:0]   seed_v;
		logic [MAXLEN_W-1:0] max_v;
		int                  first;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_SEED;
		cfg_wdata = '0;
		rx_if.valid = 1'b0;
		rx_if.in_byte = '0;
		cur_max = MAXLEN_RESET;
		steady = 1'b0;
		hold_reqs = 0;
		bytes_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(32'd0, FILL_RANDOM);
		send_frame(32'd1, FILL_ONES);
		send_frame(32'd2, FILL_ZERO);
		send_frame(32'd4097, FILL_RANDOM);
		send_frame(32'hFFFF_FFFF, FILL_RANDOM);
		quiesce();

		write_reg(REG_KEY_SEED, 24'h00);
		write_reg(REG_MAX_LEN, 24'd0);
		cur_max = 24'd0;
		send_frame(32'd0, FILL_RANDOM);
		send_frame(32'd1, FILL_RANDOM);
		send_frame(32'h00FF_FFFF, FILL_RANDOM);
		quiesce();

		write_reg(REG_KEY_SEED, 24'hFF);
		write_reg(REG_MAX_LEN, 24'hFF_FFFF);
		cur_max = 24'hFF_FFFF;
		send_frame(32'd3, FILL_RANDOM);
		send_frame(32'h0100_0000, FILL_RANDOM);
		send_frame(32'h8000_0000, FILL_RANDOM);
		send_frame(32'd0, FILL_RANDOM);
		quiesce();

		// The length limit is taken at the last header byte, the seed only when a payload opens.
		write_reg(REG_KEY_SEED, 24'h5A);
		write_reg(REG_MAX_LEN, 24'd16);
		cur_max = 24'd16;
		repeat (3) send_byte(8'h00);
		quiesce();
		write_reg(REG_MAX_LEN, 24'd24);
		cur_max = 24'd24;
		send_byte(8'd20);
		repeat (5) send_byte(BYTE_W'($urandom_range(255)));
		quiesce();
		write_reg(REG_KEY_SEED, 24'h33);
		repeat (15) send_byte(BYTE_W'($urandom_range(255)));
		send_frame(32'd2, FILL_RANDOM);
		repeat (3) send_byte(8'h00);
		quiesce();
		write_reg(REG_MAX_LEN, 24'd8);
		cur_max = 24'd8;
		send_byte(8'd16);
		quiesce();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					seed_v = 8'h5C;
					max_v = 24'd40;
				end
				1: begin
					seed_v = 8'hFF;
					max_v = 24'd1;
				end
				2: begin
					seed_v = 8'h00;
					max_v = 24'd0;
				end
				3: begin
					seed_v = SEED_W'($urandom_range(255));
					max_v = 24'hFF_FFFF;
				end
				4: begin
					seed_v = SEED_W'($urandom_range(255));
					max_v = MAXLEN_W'($urandom_range(300, 2));
				end
				default: begin
					seed_v = 8'hAB;
					max_v = 24'd12;
				end
			endcase
			write_reg(REG_KEY_SEED, {16'h0000, seed_v});
			write_reg(REG_MAX_LEN, max_v);
			cur_max = max_v;
			steady = (ph == 3);
			if (ph == 0 || ph == 3) begin
				hold_reqs++;
			end
			first = bytes_sent;
			while (bytes_sent - first < PHASE_BYTES) send_random_frame();
			quiesce();
		end
		steady = 1'b0;

		if (mismatches == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
